@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue and its cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Command codes carried on the input tuser bit
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes carried on the output tuser field
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic enq;   // insert the new entry, shifting the tail right
        logic deq;   // remove the head, shifting everything left
    } cell_ctrl_t;

endpackage

@@ hdl/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and shifts left or right.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PAYLOAD_BITS = 32,
    parameter int PRIO_BITS    = 16
) (
    input  logic                           clk,
    input  spq_pkg::cell_ctrl_t            ctrl,
    input  logic                           occupied,
    input  logic        [PAYLOAD_BITS-1:0] new_payload,
    input  logic signed [PRIO_BITS-1:0]    new_prio,
    input  logic                           left_ge,
    input  logic        [PAYLOAD_BITS-1:0] left_payload,
    input  logic signed [PRIO_BITS-1:0]    left_prio,
    input  logic        [PAYLOAD_BITS-1:0] right_payload,
    input  logic signed [PRIO_BITS-1:0]    right_prio,
    output logic                           ge,
    output logic        [PAYLOAD_BITS-1:0] payload,
    output logic signed [PRIO_BITS-1:0]    prio
);
    import spq_pkg::*;

    logic        [PAYLOAD_BITS-1:0] payload_reg;
    logic        [PAYLOAD_BITS-1:0] payload_next;
    logic signed [PRIO_BITS-1:0]    prio_reg;
    logic signed [PRIO_BITS-1:0]    prio_next;

    // Empty slots count as "not smaller" so the insertion point is monotonic
    assign ge      = !occupied || (prio_reg >= new_prio);
    assign payload = payload_reg;
    assign prio    = prio_reg;

    always_comb
    begin
        payload_next = payload_reg;
        prio_next    = prio_reg;
        if (ctrl.enq && ge)
        begin
            if (left_ge)
            begin
                payload_next = left_payload;
                prio_next    = left_prio;
            end
            else
            begin
                payload_next = new_payload;
                prio_next    = new_prio;
            end
        end
        else if (ctrl.deq)
        begin
            payload_next = right_payload;
            prio_next    = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        prio_reg    <= prio_next;
    end

endmodule

@@ hdl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// The result of each taken beat is registered in the output register.
// Throughput: one beat per cycle; every cell compares and shifts in the same cycle.
// The input stalls only while a result waits in the output register and is not taken.
// Reset clears the fill count and the output valid flag; stored entries stay undefined
// until written, and only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted by ascending priority in a shifting cell chain.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int PRIO_BITS    = 16,
    localparam int CNT_W       = $clog2(CAPACITY + 1),
    localparam int IN_W        = ((PAYLOAD_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((PAYLOAD_BITS + PRIO_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // slave side
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // payload, prio, zero pad
    input  logic             s_axis_tuser,   // cmd
    // master side
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // out_payload, out_prio, count, zero pad
    output logic [1:0]       m_axis_tuser    // status
);
    import spq_pkg::*;

    localparam int PAD_W = OUT_W - PAYLOAD_BITS - PRIO_BITS - CNT_W;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    // Unpack the incoming beat
    logic                           accept;
    logic                           in_cmd;
    logic        [PAYLOAD_BITS-1:0] in_payload;
    logic signed [PRIO_BITS-1:0]    in_prio;

    assign in_cmd     = s_axis_tuser;
    assign in_payload = s_axis_tdata[PAYLOAD_BITS-1:0];
    assign in_prio    = s_axis_tdata[PAYLOAD_BITS+PRIO_BITS-1:PAYLOAD_BITS];

    // Output register acts as the skid stage: take a beat whenever it drains
    logic out_valid_reg;
    logic out_valid_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Fill count and decoded operation
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             full;
    logic             empty;
    cell_ctrl_t       ctrl;

    assign full     = (fill_reg == CAP);
    assign empty    = (fill_reg == '0);
    assign ctrl.enq = accept && (in_cmd == CMD_ENQ) && !full;
    assign ctrl.deq = accept && (in_cmd == CMD_DEQ) && !empty;

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.enq)
            fill_next = fill_reg + CNT_W'(1);
        else if (ctrl.deq)
            fill_next = fill_reg - CNT_W'(1);
    end

    // Cell chain: slot 0 is the head
    logic                           ge_w      [CAPACITY];
    logic        [PAYLOAD_BITS-1:0] payload_w [CAPACITY];
    logic signed [PRIO_BITS-1:0]    prio_w    [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        logic                           left_ge;
        logic        [PAYLOAD_BITS-1:0] left_payload;
        logic signed [PRIO_BITS-1:0]    left_prio;
        logic        [PAYLOAD_BITS-1:0] right_payload;
        logic signed [PRIO_BITS-1:0]    right_prio;

        // Head has nothing to its left: on insert it takes the new entry whenever its ge is set
        if (i == 0)
        begin : g_head
            assign left_ge      = 1'b0;
            assign left_payload = '0;
            assign left_prio    = '0;
        end
        else
        begin : g_body
            assign left_ge      = ge_w[i-1];
            assign left_payload = payload_w[i-1];
            assign left_prio    = prio_w[i-1];
        end

        // Tail pulls in a don't-care value on removal; it lies beyond the fill
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_payload = '0;
            assign right_prio    = '0;
        end
        else
        begin : g_mid
            assign right_payload = payload_w[i+1];
            assign right_prio    = prio_w[i+1];
        end

        spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .PRIO_BITS    (PRIO_BITS)
        ) u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .occupied      (IDX < fill_reg),
            .new_payload   (in_payload),
            .new_prio      (in_prio),
            .left_ge       (left_ge),
            .left_payload  (left_payload),
            .left_prio     (left_prio),
            .right_payload (right_payload),
            .right_prio    (right_prio),
            .ge            (ge_w[i]),
            .payload       (payload_w[i]),
            .prio          (prio_w[i])
        );
    end

    // Result register
    status_t                        status_reg;
    status_t                        status_next;
    logic        [PAYLOAD_BITS-1:0] opay_reg;
    logic        [PAYLOAD_BITS-1:0] opay_next;
    logic signed [PRIO_BITS-1:0]    opri_reg;
    logic signed [PRIO_BITS-1:0]    opri_next;
    logic        [CNT_W-1:0]        ocnt_reg;
    logic        [CNT_W-1:0]        ocnt_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        opay_next      = opay_reg;
        opri_next      = opri_reg;
        ocnt_next      = ocnt_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            ocnt_next      = fill_next;
            opay_next      = '0;
            opri_next      = '0;
            status_next    = ST_OK;
            if (in_cmd == CMD_ENQ)
            begin
                if (full)
                    status_next = ST_FULL;
            end
            else if (empty)
                status_next = ST_EMPTY;
            else
            begin
                // Hand out the head as it stands before the shift
                opay_next = payload_w[0];
                opri_next = prio_w[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        opay_reg   <= opay_next;
        opri_reg   <= opri_next;
        ocnt_reg   <= ocnt_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    if (PAD_W > 0)
    begin : g_pad
        assign m_axis_tdata = {{PAD_W{1'b0}}, ocnt_reg, opri_reg, opay_reg};
    end
    else
    begin : g_nopad
        assign m_axis_tdata = {ocnt_reg, opri_reg, opay_reg};
    end

endmodule
